[design/ucs_pkg.sv]
// shared constants and codes for the uct child select and update block
// no dependencies
package ucs_pkg;

  localparam int MAX_CHILDREN = 32;
  localparam int IDX_W        = 5;
  localparam int VISIT_BITS   = 24;
  localparam int CNT_W        = 6;
  localparam int VAL_W        = 32;
  localparam int HI_W         = 31;
  localparam int WEIGHT_W     = 16;
  localparam int TOTAL_W      = 29;

  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 32;
  localparam int SQ_W    = 46;
  localparam int ROOT_W  = 23;
  localparam int SQ_STEPS = 23;

  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [VISIT_BITS-1:0] VISIT_MAX = '1;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_SELECT = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic REG_WEIGHT = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

endpackage

[design/ucs_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on ucs_pkg
module ucs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ucs_pkg::DIV_NW-1:0] dividend,
  input  logic [ucs_pkg::DIV_DW-1:0] divisor,
  output logic                      done,
  output logic [ucs_pkg::DIV_NW-1:0] quotient
);
  import ucs_pkg::*;

  logic              busy;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [5:0]        cnt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;

  assign trial = {rem, quo[DIV_NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 6'd0);
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= 6'(DIV_NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= diff[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b0};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

endmodule

[design/ucs_sqrt.sv]
// iterative integer square root, one result bit per cycle
// depends on ucs_pkg
module ucs_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ucs_pkg::SQ_W-1:0]   x,
  output logic                       done,
  output logic [ucs_pkg::ROOT_W-1:0] root
);
  import ucs_pkg::*;

  logic            busy;
  logic [SQ_W-1:0] xr;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] t;
  logic [4:0]      cnt;

  assign t    = res + bitv;
  assign root = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == 5'd0);
      if (start) begin
        xr   <= x;
        res  <= '0;
        bitv <= SQ_W'(1) << (SQ_W - 2);
        cnt  <= 5'(SQ_STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (xr >= t) begin
          xr  <= xr - t;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

[design/uct_child_select_and_update.sv]
// top level: child table, sequencer, output register
// depends on ucs_pkg, ucs_div, ucs_sqrt
//
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser is the
// action (clear, update, select, read). Results leave on m_tvalid/m_tready,
// with the status in m_tuser. Configuration writes go through cfg_valid,
// cfg_ready (always high), cfg_index and cfg_data.
// One item is in work at a time; s_tready is high only while idle.
// Clear and read need no division, and update runs one division. Select
// first sums the visit counts and takes the square root, then runs two
// divisions per child on the shared 48 step divider.
// A result waits in the output register while the receiver stalls; the
// sequencer holds the next result until that register is free, and a new
// item is taken as soon as the last result is loaded.
// Synchronous reset rst clears the child table (valid bits), sets the
// highest value to 1.0, the weight to 1 and the child count to 0.
module uct_child_select_and_update (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // child_index, new_value, zero pad
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // chosen_child, child_mean, child_visit_count,
                                 // highest_seen, zero pad
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ucs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_RD_USE, S_UPD_WAIT, S_SUM_WAIT, S_SUM_ACC, S_SQ_WAIT,
    S_SEL_WAIT, S_SEL_LOAD, S_EXP_WAIT, S_EXR_WAIT, S_RESP
  } state_t;

  state_t state;

  logic [WEIGHT_W-1:0] weight;
  logic [CNT_W-1:0]    child_count;
  logic [CNT_W-1:0]    n_eff;
  logic [VAL_W-1:0]    highest;

  logic [1:0]          act;
  logic [IDX_W-1:0]    idx;
  logic [VAL_W-1:0]    reward;
  logic [CNT_W-1:0]    n;

  // child table
  logic [VISIT_BITS-1:0] mem_vis  [MAX_CHILDREN];
  logic [VAL_W-1:0]      mem_mean [MAX_CHILDREN];
  logic [MAX_CHILDREN-1:0] ent_valid;
  logic [IDX_W-1:0]      addr;
  logic [VISIT_BITS-1:0] rd_vis_raw;
  logic [VAL_W-1:0]      rd_mean_raw;
  logic                  rd_valid;
  logic [VISIT_BITS-1:0] rd_vis;
  logic [VAL_W-1:0]      rd_mean;
  logic                  wr_en;
  logic [VISIT_BITS-1:0] wr_vis;
  logic [VAL_W-1:0]      wr_mean;

  // shared units
  logic              div_start;
  logic [DIV_NW-1:0] div_a;
  logic [DIV_DW-1:0] div_b;
  logic              div_done;
  logic [DIV_NW-1:0] div_q;
  logic              sq_start;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  logic [IDX_W-1:0]      i;
  logic [TOTAL_W-1:0]    total;
  logic [ROOT_W-1:0]     root;
  logic                  neg;
  logic [VISIT_BITS-1:0] cnt_new;
  logic [VAL_W-1:0]      cur_mean;
  logic [VISIT_BITS-1:0] cur_vis;
  logic [38:0]           prod_a;
  logic [30:0]           prod_b;
  logic signed [32:0]    exploit;
  logic signed [49:0]    best;
  logic [IDX_W-1:0]      best_idx;
  logic [VAL_W-1:0]      best_mean;
  logic [VISIT_BITS-1:0] best_vis;

  logic [1:0]            res_status;
  logic [IDX_W-1:0]      res_idx;
  logic [VAL_W-1:0]      res_mean;
  logic [VISIT_BITS-1:0] res_vis;

  logic                  in_range;
  logic                  last_child;
  logic [32:0]           diff33;
  logic [32:0]           mag33;
  logic [VAL_W-1:0]      mag32;
  logic [32:0]           delta33;
  logic [32:0]           upd_mean33;
  logic [VAL_W-1:0]      upd_mean;
  logic signed [32:0]    exploit_next;
  logic signed [49:0]    score;
  logic                  better;
  logic                  take_cur;
  logic                  do_clear;

  assign n_eff     = (child_count > CNT_W'(MAX_CHILDREN)) ? CNT_W'(MAX_CHILDREN) : child_count;
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  assign rd_vis  = rd_valid ? rd_vis_raw  : '0;
  assign rd_mean = rd_valid ? rd_mean_raw : '0;

  assign in_range   = {1'b0, idx} < n;
  assign last_child = {1'b0, i} == (n - CNT_W'(1));
  assign do_clear   = in_range && (act == ACT_CLEAR);

  always_comb begin
    diff33  = {reward[VAL_W-1], reward} - {rd_mean[VAL_W-1], rd_mean};
    mag33   = diff33[32] ? (33'd0 - diff33) : diff33;
    mag32   = rd_mean[VAL_W-1] ? (32'd0 - rd_mean) : rd_mean;
    delta33 = neg ? (33'd0 - div_q[32:0]) : div_q[32:0];
    upd_mean33 = {cur_mean[VAL_W-1], cur_mean} + delta33;
    upd_mean   = upd_mean33[VAL_W-1:0];
    exploit_next = neg ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});
    score    = 50'(exploit) + $signed({3'b0, div_q[46:0]});
    better   = score > best;
    take_cur = better || (i == '0);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_vis  = '0;
    wr_mean = '0;
    if (state == S_RD_USE && do_clear) begin
      wr_en = 1'b1;
    end else if (state == S_UPD_WAIT && div_done) begin
      wr_en   = 1'b1;
      wr_vis  = cnt_new;
      wr_mean = upd_mean;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_vis[idx]  <= wr_vis;
      mem_mean[idx] <= wr_mean;
    end
    rd_vis_raw  <= mem_vis[addr];
    rd_mean_raw <= mem_mean[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_valid[idx] <= 1'b1;
      end
      rd_valid <= ent_valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight      <= WEIGHT_W'(1);
      child_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WEIGHT: weight      <= cfg_data;
        REG_COUNT:  child_count <= cfg_data[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  ucs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  ucs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     ({1'b0, total, 16'b0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      highest   <= ONE_Q16;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      // start pulses for the shared units
      div_start <= (state == S_RD_USE && in_range && act == ACT_UPDATE) ||
                   (state == S_SEL_LOAD) || (state == S_EXP_WAIT && div_done);
      sq_start  <= (state == S_SUM_ACC) && last_child;
      if (m_tvalid && m_tready && state != S_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act    <= s_tuser;
            idx    <= s_tdata[4:0];
            reward <= s_tdata[36:5];
            n      <= n_eff;
            if (s_tuser == ACT_SELECT) begin
              i     <= '0;
              addr  <= '0;
              total <= '0;
              if (n_eff == '0) begin
                res_status <= ST_EMPTY;
                res_idx    <= '0;
                res_mean   <= '0;
                res_vis    <= '0;
                state      <= S_RESP;
              end else begin
                state <= S_SUM_WAIT;
              end
            end else begin
              addr  <= s_tdata[4:0];
              state <= S_RD_WAIT;
            end
          end
        end
        S_RD_WAIT: state <= S_RD_USE;
        S_RD_USE: begin
          res_idx    <= idx;
          res_status <= in_range ? ST_OK : ST_RANGE;
          res_mean   <= do_clear ? '0 : rd_mean;
          res_vis    <= do_clear ? '0 : rd_vis;
          cur_mean   <= rd_mean;
          if (in_range && act == ACT_UPDATE) begin
            cnt_new   <= (rd_vis == VISIT_MAX) ? rd_vis : rd_vis + VISIT_BITS'(1);
            neg       <= diff33[32];
            div_a     <= {15'b0, mag33};
            div_b     <= {8'b0, ((rd_vis == VISIT_MAX) ? rd_vis : rd_vis + VISIT_BITS'(1))};
            state     <= S_UPD_WAIT;
          end else begin
            state <= S_RESP;
          end
        end
        S_UPD_WAIT: begin
          if (div_done) begin
            res_mean <= upd_mean;
            res_vis  <= cnt_new;
            if ($signed(upd_mean) > $signed(highest)) begin
              highest <= upd_mean;
            end
            state <= S_RESP;
          end
        end
        S_SUM_WAIT: state <= S_SUM_ACC;
        S_SUM_ACC: begin
          total <= total + TOTAL_W'(rd_vis);
          if (last_child) begin
            state <= S_SQ_WAIT;
          end else begin
            i     <= i + IDX_W'(1);
            addr  <= i + IDX_W'(1);
            state <= S_SUM_WAIT;
          end
        end
        S_SQ_WAIT: begin
          if (sq_done) begin
            root     <= sq_root;
            i        <= '0;
            addr     <= '0;
            best     <= '0;
            best_idx <= '0;
            state    <= S_SEL_WAIT;
          end
        end
        S_SEL_WAIT: state <= S_SEL_LOAD;
        S_SEL_LOAD: begin
          cur_mean  <= rd_mean;
          cur_vis   <= rd_vis;
          neg       <= rd_mean[VAL_W-1];
          div_a     <= {mag32, 16'b0};
          div_b     <= highest;
          prod_a    <= 39'(weight) * 39'(root);
          prod_b    <= 31'(n) * 31'({1'b0, rd_vis} + 25'd1);
          state     <= S_EXP_WAIT;
        end
        S_EXP_WAIT: begin
          if (div_done) begin
            exploit   <= exploit_next;
            div_a     <= {1'b0, prod_a, 8'b0};
            div_b     <= {1'b0, prod_b};
            state     <= S_EXR_WAIT;
          end
        end
        S_EXR_WAIT: begin
          if (div_done) begin
            if (better) begin
              best     <= score;
              best_idx <= i;
            end
            if (take_cur) begin
              best_mean <= cur_mean;
              best_vis  <= cur_vis;
            end
            if (last_child) begin
              res_status <= ST_OK;
              res_idx    <= better ? i : best_idx;
              res_mean   <= take_cur ? cur_mean : best_mean;
              res_vis    <= take_cur ? cur_vis : best_vis;
              state      <= S_RESP;
            end else begin
              i     <= i + IDX_W'(1);
              addr  <= i + IDX_W'(1);
              state <= S_SEL_WAIT;
            end
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {4'b0, highest[HI_W-1:0], res_vis, res_mean, res_idx};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // running highest never drops below one and never falls
  a_highest_floor: assert property (@(posedge clk) disable iff (rst)
    $signed(highest) >= $signed(ONE_Q16))
    else $error("highest value below one");

  a_highest_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $signed(highest) >= $signed($past(highest)))
    else $error("highest value decreased");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_RANGE))
    else $error("bad status code");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

endmodule
